FILE: sv/twdc_pkg.sv
`timescale 1ns / 1ps
// Package for the term week/day to calendar date block.
// Holds the date type, the register indexes, the calendar constants and
// the month length and leap year functions. No dependencies.
package twdc_pkg;

	// Calendar date as carried between the sequencer and the step unit.
	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} twdc_date_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_DONE
	} twdc_state_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_START_YEAR  = 2'd0;
	localparam logic [1:0] CFG_START_MONTH = 2'd1;
	localparam logic [1:0] CFG_START_DAY   = 2'd2;

	// Register reset values.
	localparam logic [11:0] RST_YEAR  = 12'd2026;
	localparam logic [3:0]  RST_MONTH = 4'd6;
	localparam logic [4:0]  RST_DAY   = 5'd29;

	// Accepted start years and calendar constants.
	localparam logic [11:0] YEAR_MIN      = 12'd2020;
	localparam logic [11:0] YEAR_MAX      = 12'd2099;
	localparam logic [11:0] CENTURY_YEAR  = 12'd2100;
	localparam logic [3:0]  MONTH_FIRST   = 4'd1;
	localparam logic [3:0]  MONTH_FEB     = 4'd2;
	localparam logic [3:0]  MONTH_LAST    = 4'd12;
	localparam logic [4:0]  DAYS_FEB_LEAP = 5'd29;
	localparam logic [4:0]  DAY_FIRST     = 5'd1;
	localparam int          DAYS_PER_WEEK = 7;

	// Month lengths of a common year, January first.
	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// Leap year test. Dates only ever range over 2020..2100, where the
	// only century year is 2100, which is not a leap year; no year in that
	// range is a multiple of 400.
	function automatic logic is_leap(input logic [11:0] y);
		return (y[1:0] == 2'b00) && (y != CENTURY_YEAR);
	endfunction

	// Days in month m of year y, zero for a month code outside 1..12.
	function automatic logic [4:0] month_length(input logic [11:0] y, input logic [3:0] m);
		logic [3:0] idx;
		idx = m - MONTH_FIRST;
		if (m < MONTH_FIRST || m > MONTH_LAST) begin
			return 5'd0;
		end else if (m == MONTH_FEB && is_leap(y)) begin
			return DAYS_FEB_LEAP;
		end else begin
			return MONTH_LEN[idx];
		end
	endfunction

endpackage

FILE: sv/twdc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input and result items.
// Depends on nothing.
interface twdc_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] week;
	logic [7:0] weekday;

	modport source (output valid, week, weekday, input ready);
	modport sink (input valid, week, weekday, output ready);
endinterface

interface twdc_rsp_if;
	logic        valid;
	logic        ready;
	logic [11:0] out_year;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic        start_valid;

	modport source (output valid, out_year, out_month, out_day, start_valid, input ready);
	modport sink (input valid, out_year, out_month, out_day, start_valid, output ready);
endinterface

FILE: sv/twdc_step.sv
`timescale 1ns / 1ps
// Month step unit: advances a date by the remaining day count by at most
// one month boundary per use. Depends on twdc_pkg.
module twdc_step
	import twdc_pkg::*;
#(
	parameter int DAYS_W = 8
) (
	input  twdc_date_t        date,
	input  logic [DAYS_W-1:0] days,
	output twdc_date_t        date_next,
	output logic [DAYS_W-1:0] days_next,
	output logic              done
);

	localparam int CW = (DAYS_W > 5) ? DAYS_W : 5;

	logic [4:0]    left;
	logic [CW-1:0] days_x;
	logic [CW-1:0] left_x;

	// Days left in the current month after the current day.
	always_comb begin
		left   = month_length(date.year, date.month) - date.day;
		days_x = CW'(days);
		left_x = CW'(left);
	end

	// Either finish inside this month or move to the first of the next one.
	always_comb begin
		date_next = date;
		days_next = days;
		done      = 1'b0;
		if (days_x <= left_x) begin
			date_next.day = date.day + left_x[4:0] - (left_x[4:0] - days_x[4:0]);
			days_next     = '0;
			done          = 1'b1;
		end else begin
			days_next     = DAYS_W'(days_x - left_x - CW'(1));
			date_next.day = DAY_FIRST;
			if (date.month >= MONTH_LAST) begin
				date_next.month = MONTH_FIRST;
				date_next.year  = date.year + 12'd1;
			end else begin
				date_next.month = date.month + 4'd1;
			end
		end
	end

endmodule

FILE: sv/term_week_day_to_calendar_date_core.sv
`timescale 1ns / 1ps
// Term week/day to calendar date. The item is taken in ST_IDLE, the month
// step loop in ST_STEP crosses one month boundary per cycle in the shared step
// unit (at most 5 boundaries), and ST_DONE loads the result register; an item
// with an invalid start date skips the loop. A new item is taken only after
// the result is loaded, which waits while the previous result is not taken.
// Reset clears the sequencer and output valid and loads the start date 2026-06-29.
module term_week_day_to_calendar_date_core
	import twdc_pkg::*;
#(
	parameter int WEEKS     = 18,
	parameter int DAY_SLOTS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	twdc_req_if.sink    req,
	twdc_rsp_if.source  rsp
);

	localparam int MAX_DAYS = (WEEKS - 1) * DAYS_PER_WEEK + DAY_SLOTS - 1;
	localparam int DAYS_RAW = $clog2(MAX_DAYS + 1);
	localparam int DAYS_W   = (DAYS_RAW < 1) ? 1 : DAYS_RAW;

	twdc_state_t       state_q, state_d;
	twdc_date_t        start_q;
	twdc_date_t        date_q;
	twdc_date_t        date_next;
	logic [DAYS_W-1:0] days_q;
	logic [DAYS_W-1:0] days_next;
	logic [DAYS_W-1:0] days_calc;
	logic              step_done;
	logic              ok_q;
	logic              start_ok;
	logic [7:0]        week_c;
	logic [7:0]        wd_c;
	logic [15:0]       days_wide;
	logic              accept;
	logic              out_load;
	logic              out_valid_q;
	twdc_date_t        out_date_q;
	logic              out_ok_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q.year  <= RST_YEAR;
			start_q.month <= RST_MONTH;
			start_q.day   <= RST_DAY;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_YEAR:  start_q.year  <= cfg_data[11:0];
				CFG_START_MONTH: start_q.month <= cfg_data[3:0];
				CFG_START_DAY:   start_q.day   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Start date check: year range, month range and day within the month.
	always_comb begin
		start_ok = (start_q.year >= YEAR_MIN) && (start_q.year <= YEAR_MAX)
			&& (start_q.month >= MONTH_FIRST) && (start_q.month <= MONTH_LAST)
			&& (start_q.day >= DAY_FIRST)
			&& (start_q.day <= month_length(start_q.year, start_q.month));
	end

	// Clamp the week and weekday and form the day offset.
	always_comb begin
		if (req.week == 8'd0) begin
			week_c = 8'd1;
		end else if (req.week > 8'(WEEKS)) begin
			week_c = 8'(WEEKS);
		end else begin
			week_c = req.week;
		end
		if (req.weekday >= 8'(DAY_SLOTS)) begin
			wd_c = 8'(DAY_SLOTS - 1);
		end else begin
			wd_c = req.weekday;
		end
		days_wide = 16'((16'(week_c) - 16'd1) * 16'(DAYS_PER_WEEK) + 16'(wd_c));
		days_calc = DAYS_W'(days_wide);
	end

	// Shared month step unit.
	twdc_step #(
		.DAYS_W (DAYS_W)
	) u_step (
		.date      (date_q),
		.days      (days_q),
		.date_next (date_next),
		.days_next (days_next),
		.done      (step_done)
	);

	assign accept   = req.valid && req.ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and input ready.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = start_ok ? ST_STEP : ST_DONE;
				end
			end
			ST_STEP: begin
				if (step_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Working date and day count; loaded on an item, stepped once a cycle in ST_STEP.
	always_ff @(posedge clk) begin
		if (accept) begin
			date_q <= start_q;
			days_q <= days_calc;
			ok_q   <= start_ok;
		end else if (state_q == ST_STEP && !step_done) begin
			date_q <= date_next;
			days_q <= days_next;
		end else if (state_q == ST_STEP) begin
			date_q <= date_next;
			days_q <= days_next;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_date_q <= date_q;
			out_ok_q   <= ok_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.out_year    = out_date_q.year;
	assign rsp.out_month   = out_date_q.month;
	assign rsp.out_day     = out_date_q.day;
	assign rsp.start_valid = out_ok_q;

`ifndef NO_ASSERTIONS
	// While stepping, the working date stays a real date in range.
	a_step_date: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (date_q.month >= MONTH_FIRST && date_q.month <= MONTH_LAST
			&& date_q.day >= DAY_FIRST
			&& date_q.day <= month_length(date_q.year, date_q.month)))
		else $error("working date out of range while stepping");

	// Years only run from the first allowed start year to one past the last.
	a_step_year: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (date_q.year >= YEAR_MIN && date_q.year <= CENTURY_YEAR))
		else $error("working year out of range");

	// An item with a bad start date skips the step loop.
	a_bad_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !start_ok) |=> (state_q == ST_DONE && !ok_q))
		else $error("invalid start date entered the step loop");

	// Loading the result returns the sequencer to idle with a valid result.
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result load did not complete the item");
`endif

endmodule
